// File: src/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// Plain invariant checked on every rising clock edge outside reset.
`define ASSERT_ALW(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error(msg);

`endif

// File: src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared types and codes for the heap request sequencer.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Heap size and the widths that follow from it.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = 6;
  localparam int unsigned CW       = 7;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_DECR    = 2'd2,
    REQ_DELETE  = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage

// File: src/mhpq_store.sv
// ----------------------------------------------------------------------------
// Heap key store
// Single-port write, single-port read synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module mhpq_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);

  logic signed [31:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/min_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Min-heap priority queue unit
// Channel   Dir  Beat contents
// s_axis    in   tuser: req_type[1:0]; tdata: key_value[31:0], entry_index[37:32]
// m_axis    out  tuser: status[1:0]; tdata: min_key[31:0], entry_count[38:32]
// cfg       in   capacity_limit[6:0], written when cfg_we_i is high
// One request at a time. Each sift-up level reads the parent (S_UP_RD), then
// compares (S_UP_CMP); each sift-down level reads the left child (S_DN_RD),
// the right child (S_DN_RDR), then compares (S_DN_CMP), as the key store read
// is registered. An extract fetches the root and the last key (S_POP_RD,
// S_POP_LAST, S_DN_LOAD); every result goes through S_DONE. Reset clears the
// count and the output valid flag and sets the limit to 64; stored keys stay
// undefined until written. A finished result waits in the output register
// while the next request runs; only a second result stalls until it frees.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit import mhpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_value[31:0], entry_index[37:32], zero pad[39:38]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // min_key[31:0], entry_count[38:32], zero pad[39]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [6:0]         limit_q;
  logic [AW-1:0]      pos_q, pos_d, best_q, best_d;
  logic signed [31:0] cur_q, cur_d, bkey_q, bkey_d, res_q, res_d;
  logic [1:0]         stat_q, stat_d;
  logic               del_q, del_d;

  logic               out_valid_q;
  logic signed [31:0] out_key_q;
  logic [1:0]         out_stat_q;
  logic [CW-1:0]      out_count_q;
  logic               out_load;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata, rdata;

  mhpq_store #(.Depth(CAPACITY), .AW(AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Request fields.
  req_e               req;
  logic signed [31:0] in_key;
  logic [5:0]         in_idx;
  logic [CW-1:0]      cap_eff, idx_ext;
  assign req     = req_e'(s_axis_tuser);
  assign in_key  = s_axis_tdata[31:0];
  assign in_idx  = s_axis_tdata[37:32];
  assign cap_eff = (limit_q > CW'(CAPACITY)) ? CW'(CAPACITY) : limit_q;
  assign idx_ext = CW'(in_idx);

  // Child and parent positions, widened for compares against the count.
  logic [AW:0] lt_w, rt_w, par_w;
  assign lt_w  = {pos_q, 1'b1};
  assign rt_w  = {pos_q, 1'b0} + (AW+1)'(2);
  assign par_w = ((AW+1)'(pos_q) - (AW+1)'(1)) >> 1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_key_q};
  assign m_axis_tuser  = out_stat_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 7'd64;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    best_q <= best_d;
    cur_q  <= cur_d;
    bkey_q <= bkey_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    del_q  <= del_d;
  end

  // Output register: holds one finished result until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q   <= res_q;
      out_stat_q  <= stat_q;
      out_count_q <= count_q;
    end
  end

  // Sequencer: sift-up compares the carried key against the parent, sift-down
  // reads both children and swaps by writing the smaller child upward.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    best_d  = best_q;
    cur_d   = cur_q;
    bkey_d  = bkey_q;
    res_d   = res_q;
    stat_d  = stat_q;
    del_d   = del_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = cur_q;
    raddr   = pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d  = '0;
          stat_d = ST_OK;
          del_d  = (req == REQ_DELETE);
          unique case (req)
            REQ_INSERT: begin
              if (count_q >= cap_eff) begin
                stat_d  = ST_FULL;
                state_d = S_DONE;
              end else begin
                pos_d   = AW'(count_q);
                cur_d   = in_key;
                count_d = count_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            REQ_EXTRACT: begin
              if (count_q == '0) begin
                res_d   = KEY_MAX;
                stat_d  = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_POP_RD;
              end
            end
            default: begin
              if (idx_ext >= count_q) begin
                stat_d  = ST_RANGE;
                state_d = S_DONE;
              end else begin
                pos_d   = AW'(in_idx);
                cur_d   = (req == REQ_DECR) ? in_key : KEY_MIN;
                state_d = S_UP_RD;
              end
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          we = 1'b1;
          state_d = del_q ? S_POP_RD : S_DONE;
        end else begin
          raddr   = AW'(par_w);
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // Parent greater: move it down and climb.
        if (rdata > cur_q) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = AW'(par_w);
          state_d = S_UP_RD;
        end else begin
          we      = 1'b1;
          state_d = del_q ? S_POP_RD : S_DONE;
        end
      end
      S_POP_RD: begin
        raddr   = '0;
        state_d = S_POP_LAST;
      end
      S_POP_LAST: begin
        if (!del_q) begin
          res_d = rdata;
        end
        count_d = count_q - CW'(1);
        raddr   = AW'(count_q - CW'(1));
        pos_d   = '0;
        state_d = (count_q == CW'(1)) ? S_DONE : S_DN_LOAD;
      end
      S_DN_LOAD: begin
        // The last entry becomes the key carried down from the root.
        cur_d   = rdata;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        if ((CW+1)'(lt_w) >= (CW+1)'(count_q)) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          raddr   = AW'(lt_w);
          state_d = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        best_d = AW'(lt_w);
        bkey_d = rdata;
        raddr  = AW'(rt_w);
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if ((CW+1)'(rt_w) < (CW+1)'(count_q) && rdata < bkey_q) begin
          if (rdata < cur_q) begin
            we      = 1'b1;
            wdata   = rdata;
            pos_d   = AW'(rt_w);
            state_d = S_DN_RD;
          end else begin
            we      = 1'b1;
            state_d = S_DONE;
          end
        end else if (bkey_q < cur_q) begin
          we      = 1'b1;
          wdata   = bkey_q;
          pos_d   = best_q;
          state_d = S_DN_RD;
        end else begin
          we      = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_ALW(a_count_le_cap, clk_i, rst_ni, count_q <= CW'(CAPACITY), "count over capacity")
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while held")
  `ASSERT_IMP(a_empty_key, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_EMPTY, m_axis_tdata[31:0] == KEY_MAX, "empty result key")

endmodule
